### rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character map of the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int MAX_TOKENS    = 6;
    localparam int QUEUE_DEPTH_D = 2;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_CHAR_62   = 3'd0;
    localparam logic [2:0] REG_CHAR_63   = 3'd1;
    localparam logic [2:0] REG_PAD_SYM   = 3'd2;
    localparam logic [2:0] REG_PAD_EN    = 3'd3;
    localparam logic [2:0] REG_LINE_LEN  = 3'd4;

    localparam logic [7:0] RST_CHAR_62   = 8'd43;
    localparam logic [7:0] RST_CHAR_63   = 8'd47;
    localparam logic [7:0] RST_PAD_SYM   = 8'd61;
    localparam logic       RST_PAD_EN    = 1'b1;
    localparam logic [9:0] RST_LINE_LEN  = 10'd0;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    typedef enum logic [1:0] {
        TK_SEXTET,
        TK_PAD,
        TK_CR,
        TK_LF
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [5:0] val;
    } tok_t;

    typedef struct packed {
        tok_t [MAX_TOKENS-1:0] toks;
        logic [2:0]            count;
    } entry_t;

    typedef struct packed {
        logic [7:0] char_62;
        logic [7:0] char_63;
        logic [7:0] pad_symbol;
        logic       pad_enable;
        logic [9:0] line_length;
    } cfg_t;

    function automatic logic [7:0] tok_char(tok_t tok, cfg_t cfg);
        logic [7:0] v;
        logic [7:0] c;
        v = {2'b00, tok.val};
        case (tok.kind)
            TK_SEXTET:
            begin
                if (v < 8'd26)
                    c = 8'd65 + v;
                else if (v < 8'd52)
                    c = 8'd97 + (v - 8'd26);
                else if (v < 8'd62)
                    c = 8'd48 + (v - 8'd52);
                else if (v == 8'd62)
                    c = cfg.char_62;
                else
                    c = cfg.char_63;
            end
            TK_PAD:  c = cfg.pad_symbol;
            TK_CR:   c = CHAR_CR;
            TK_LF:   c = CHAR_LF;
            default: c = CHAR_LF;
        endcase
        return c;
    endfunction

endpackage

### rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Takes message bytes, tracks group position and line count, and turns each
// byte into a list of output tokens for the back end.
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       line_len_wr,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       queue_full,
    output logic       push,
    output entry_t     push_entry
);

    logic [5:0] carry_reg, carry_next;
    logic [1:0] gpos_reg, gpos_next;
    logic [9:0] lc_reg, lc_next;

    // line count reduction after a line length write
    logic       red_active_reg, red_active_next;
    logic [3:0] red_cnt_reg, red_cnt_next;
    logic [9:0] red_rem_reg, red_rem_next;
    logic [9:0] red_shift_reg, red_shift_next;
    logic [10:0] red_trial;

    logic [5:0]  tok0, tok1;
    logic [5:0]  carry_upd;
    logic [1:0]  gpos_upd;
    logic [1:0]  pads;
    logic [2:0]  chars;
    logic        full_grp;
    logic        fin_grp;
    logic        do_gd;
    logic [10:0] rem;
    logic        brk;
    logic [2:0]  pad_end;

    assign byte_stall = red_active_reg | queue_full;
    assign push       = byte_valid & ~byte_stall;

    always_comb
    begin
        tok1 = data_byte[5:0];
        case (gpos_reg)
            2'd0:
            begin
                tok0      = data_byte[7:2];
                carry_upd = {data_byte[1:0], 4'b0000};
                gpos_upd  = 2'd1;
            end
            2'd1:
            begin
                tok0      = carry_reg | {2'b00, data_byte[7:4]};
                carry_upd = {data_byte[3:0], 2'b00};
                gpos_upd  = 2'd2;
            end
            default:
            begin
                tok0      = carry_reg | {4'b0000, data_byte[7:6]};
                carry_upd = 6'd0;
                gpos_upd  = 2'd0;
            end
        endcase

        full_grp = (gpos_upd == 2'd0);
        fin_grp  = last_byte & ~full_grp;
        do_gd    = full_grp | fin_grp;
        pads     = cfg.pad_enable ? (2'd3 - gpos_upd) : 2'd0;
        chars    = full_grp ? 3'd4 : ({1'b0, gpos_upd} + 3'd1 + {1'b0, pads});

        rem = {1'b0, lc_reg} + {8'd0, chars};
        for (int i = 0; i < 4; i++)
        begin
            if (rem >= {1'b0, cfg.line_length})
                rem = rem - {1'b0, cfg.line_length};
        end
        brk = do_gd & (cfg.line_length != 10'd0) & (rem == 11'd0);

        push_entry = '0;
        pad_end    = 3'd2 + {1'b0, pads};
        if (fin_grp)
        begin
            for (int i = 0; i < MAX_TOKENS; i++)
            begin
                if (i == 0)
                    push_entry.toks[i] = '{kind: TK_SEXTET, val: tok0};
                else if (i == 1)
                    push_entry.toks[i] = '{kind: TK_SEXTET, val: carry_upd};
                else if (3'(i) < pad_end)
                    push_entry.toks[i] = '{kind: TK_PAD, val: 6'd0};
                else if (3'(i) == pad_end)
                    push_entry.toks[i] = '{kind: TK_CR, val: 6'd0};
                else
                    push_entry.toks[i] = '{kind: TK_LF, val: 6'd0};
            end
            push_entry.count = pad_end + (brk ? 3'd2 : 3'd0);
        end
        else
        begin
            push_entry.toks[0] = '{kind: TK_SEXTET, val: tok0};
            push_entry.toks[1] = '{kind: TK_SEXTET, val: tok1};
            push_entry.toks[2] = '{kind: TK_CR, val: 6'd0};
            push_entry.toks[3] = '{kind: TK_LF, val: 6'd0};
            push_entry.count   = full_grp ? (brk ? 3'd4 : 3'd2) : 3'd1;
        end
    end

    always_comb
    begin
        carry_next      = carry_reg;
        gpos_next       = gpos_reg;
        lc_next         = lc_reg;
        red_active_next = red_active_reg;
        red_cnt_next    = red_cnt_reg;
        red_rem_next    = red_rem_reg;
        red_shift_next  = red_shift_reg;
        red_trial       = {red_rem_reg, red_shift_reg[9]};

        if (line_len_wr)
        begin
            red_active_next = 1'b1;
            red_cnt_next    = 4'd0;
            red_rem_next    = 10'd0;
            red_shift_next  = lc_reg;
        end
        else if (red_active_reg)
        begin
            if (cfg.line_length == 10'd0)
            begin
                red_active_next = 1'b0;
            end
            else
            begin
                if (red_trial >= {1'b0, cfg.line_length})
                    red_trial = red_trial - {1'b0, cfg.line_length};
                red_rem_next   = red_trial[9:0];
                red_shift_next = {red_shift_reg[8:0], 1'b0};
                red_cnt_next   = red_cnt_reg + 4'd1;
                if (red_cnt_reg == 4'd9)
                begin
                    red_active_next = 1'b0;
                    lc_next         = red_trial[9:0];
                end
            end
        end

        if (push)
        begin
            if (last_byte)
            begin
                carry_next = 6'd0;
                gpos_next  = 2'd0;
                lc_next    = 10'd0;
            end
            else
            begin
                carry_next = carry_upd;
                gpos_next  = gpos_upd;
                if (do_gd && cfg.line_length != 10'd0)
                    lc_next = rem[9:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg      <= 6'd0;
            gpos_reg       <= 2'd0;
            lc_reg         <= 10'd0;
            red_active_reg <= 1'b0;
            red_cnt_reg    <= 4'd0;
            red_rem_reg    <= 10'd0;
            red_shift_reg  <= 10'd0;
        end
        else
        begin
            carry_reg      <= carry_next;
            gpos_reg       <= gpos_next;
            lc_reg         <= lc_next;
            red_active_reg <= red_active_next;
            red_cnt_reg    <= red_cnt_next;
            red_rem_reg    <= red_rem_next;
            red_shift_reg  <= red_shift_next;
        end
    end

    a_red_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        red_active_reg |-> byte_stall)
        else $error("byte taken during line count reduction");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_entry.count != 3'd0 && push_entry.count <= 3'(MAX_TOKENS)))
        else $error("token count out of range");

    a_lc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (!red_active_reg && cfg.line_length != 10'd0) |-> (lc_reg < cfg.line_length))
        else $error("line count not below line length");

endmodule

### rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Small FIFO of token lists between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_D
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue underflow");

endmodule

### rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head token list, one output character per cycle while the
// receiver does not stall, into a registered output stage.
// ----------------------------------------------------------------------------
module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       head_valid,
    input  entry_t     head_entry,
    output logic       pop,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [7:0] out_char,
    output logic       run_end
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       end_reg, end_next;
    logic       load;
    logic       at_last;

    assign load       = head_valid & (~valid_reg | ~char_stall);
    assign at_last    = (idx_reg == head_entry.count - 3'd1);
    assign pop        = load & at_last;
    assign char_valid = valid_reg;
    assign out_char   = char_reg;
    assign run_end    = end_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        end_next   = end_reg;
        if (load)
        begin
            valid_next = 1'b1;
            char_next  = tok_char(head_entry.toks[idx_reg], cfg);
            end_next   = at_last;
            idx_next   = at_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (valid_reg && !char_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        end_reg  <= end_next;
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head_entry.count))
        else $error("token index beyond list");

endmodule

### rtl/base64_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Byte-in, character-out base64 encoder with configurable symbols, padding
// and CR LF line breaks.
// ----------------------------------------------------------------------------
// The back end emits one character per cycle while char_stall is low; a byte
// produces 1 character for most bytes, 2 (4 with a line break) for the byte
// that closes a group, up to 6 for a short last group with padding and break;
// about 4 characters per 3 bytes on long messages. The front end takes a
// byte per cycle while the QUEUE_DEPTH-entry token queue has room. Each write
// of line_length starts a bit-serial pass that reduces the line count modulo
// the new length, during which no byte is taken.
module base64_stream_encoder_top
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              char_valid,
    input  logic              char_stall,
    output logic [7:0]        out_char,
    output logic              run_end
);

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       line_len_wr;
    logic       queue_full;
    logic       push;
    entry_t     push_entry;
    logic       pop;
    logic       head_valid;
    entry_t     head_entry;

    assign pready      = 1'b1;
    assign wr_en       = psel & penable & pwrite;
    assign reg_idx     = paddr[4:2];
    assign line_len_wr = wr_en & (reg_idx == REG_LINE_LEN);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_CHAR_62:  cfg_next.char_62     = pwdata[7:0];
                REG_CHAR_63:  cfg_next.char_63     = pwdata[7:0];
                REG_PAD_SYM:  cfg_next.pad_symbol  = pwdata[7:0];
                REG_PAD_EN:   cfg_next.pad_enable  = pwdata[0];
                REG_LINE_LEN: cfg_next.line_length = pwdata[9:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CHAR_62:  prdata = {24'd0, cfg_reg.char_62};
            REG_CHAR_63:  prdata = {24'd0, cfg_reg.char_63};
            REG_PAD_SYM:  prdata = {24'd0, cfg_reg.pad_symbol};
            REG_PAD_EN:   prdata = {31'd0, cfg_reg.pad_enable};
            REG_LINE_LEN: prdata = {22'd0, cfg_reg.line_length};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.char_62     <= RST_CHAR_62;
            cfg_reg.char_63     <= RST_CHAR_63;
            cfg_reg.pad_symbol  <= RST_PAD_SYM;
            cfg_reg.pad_enable  <= RST_PAD_EN;
            cfg_reg.line_length <= RST_LINE_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    b64e_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .line_len_wr (line_len_wr),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .queue_full  (queue_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .run_end    (run_end)
    );

endmodule

### verif/base64_stream_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_top_tb
// Drives messages of raw bytes into the base64 encoder and checks every
// character word against an in-bench prediction. Covers the configurable
// symbols, padding on and off, and line breaks at several line lengths,
// including changes between phases in the middle of a message.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module base64_stream_encoder_top_tb;
    import b64e_pkg::*;

    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         SETTLE_CYCLES  = 20;
    localparam int         HOLD_CYCLES    = 100;
    localparam int         RANDOM_PHASES  = 6;
    localparam int         PHASE_BYTES    = 24;
    localparam logic [2:0] REG_UNUSED     = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } byte_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_word_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              byte_valid = 1'b0;
    logic              byte_stall;
    logic [7:0]        data_byte  = 8'd0;
    logic              last_byte  = 1'b0;
    logic              char_valid;
    logic              char_stall = 1'b0;
    logic [7:0]        out_char;
    logic              run_end;

    byte_word_t raw_bytes[$];
    char_word_t expected_chars[$];

    string      digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";

    // predicted configuration and encoder state
    logic [7:0] cfg_c62      = RST_CHAR_62;
    logic [7:0] cfg_c63      = RST_CHAR_63;
    logic [7:0] cfg_pad      = RST_PAD_SYM;
    logic       cfg_pad_en   = RST_PAD_EN;
    logic [9:0] cfg_line_len = RST_LINE_LEN;
    logic [5:0] carry        = '0;
    logic [1:0] grp_pos      = '0;
    logic [9:0] line_cnt     = '0;

    int         bytes_taken = 0;
    int         err_count   = 0;
    int         idle_cycles = 0;
    int         hold_left   = 0;
    int         hold_at     = 40;

    wire calm = (bytes_taken >= 90) && (bytes_taken < 130);

    base64_stream_encoder_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .run_end    (run_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        if (v == 6'd62)
            return cfg_c62;
        if (v == 6'd63)
            return cfg_c63;
        return digits[v];
    endfunction

    // advance the line count by n characters, 1 when a break is due
    function automatic bit line_full(input int n);
        if (cfg_line_len == 10'd0)
            return 1'b0;
        line_cnt = 10'((int'(line_cnt) + n) % int'(cfg_line_len));
        return line_cnt == 10'd0;
    endfunction

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] chars[$];
        int         n_grp;
        case (grp_pos)
            2'd0:
            begin
                chars.push_back(b64_symbol(b[7:2]));
                carry   = {b[1:0], 4'b0000};
                grp_pos = 2'd1;
            end
            2'd1:
            begin
                chars.push_back(b64_symbol(carry | {2'b00, b[7:4]}));
                carry   = {b[3:0], 2'b00};
                grp_pos = 2'd2;
            end
            default:
            begin
                chars.push_back(b64_symbol(carry | {4'b0000, b[7:6]}));
                chars.push_back(b64_symbol(b[5:0]));
                carry   = '0;
                grp_pos = 2'd0;
                if (line_full(4))
                begin
                    chars.push_back(CHAR_CR);
                    chars.push_back(CHAR_LF);
                end
            end
        endcase
        if (fin)
        begin
            if (grp_pos != 2'd0)
            begin
                n_grp = int'(grp_pos) + 1;
                chars.push_back(b64_symbol(carry));
                if (cfg_pad_en)
                begin
                    for (int i = 0; i < 3 - int'(grp_pos); i++)
                        chars.push_back(cfg_pad);
                    n_grp += 3 - int'(grp_pos);
                end
                if (line_full(n_grp))
                begin
                    chars.push_back(CHAR_CR);
                    chars.push_back(CHAR_LF);
                end
            end
            carry    = '0;
            grp_pos  = '0;
            line_cnt = '0;
        end
        foreach (chars[i])
            expected_chars.push_back('{chars[i], i == chars.size() - 1});
    endtask

    task automatic flag_error(input string msg);
        if (err_count < 10)
            $display("%0t mismatch: %s", $time, msg);
        err_count++;
    endtask

    // byte driver
    always @(posedge clk)
    begin
        byte_word_t w;
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                encode_byte(data_byte, last_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (!byte_valid || !byte_stall)
            begin
                if (raw_bytes.size() != 0 && (calm || $urandom_range(99) >= 20))
                begin
                    w = raw_bytes.pop_front();
                    byte_valid <= 1'b1;
                    data_byte  <= w.data;
                    last_byte  <= w.fin;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // character monitor and receiver stall
    always @(posedge clk)
    begin
        char_word_t e;
        if (rst_n)
        begin
            if (char_valid && !char_stall)
            begin
                if (expected_chars.size() == 0)
                    flag_error($sformatf("unexpected char %02h run_end %0b",
                                         out_char, run_end));
                else
                begin
                    e = expected_chars.pop_front();
                    if (out_char !== e.ch || run_end !== e.fin)
                        flag_error($sformatf("exp char %02h run_end %0b, got %02h %0b",
                                             e.ch, e.fin, out_char, run_end));
                end
            end
            if (hold_left > 0)
            begin
                char_stall <= 1'b1;
                hold_left  <= hold_left - 1;
            end
            else if (bytes_taken >= hold_at)
            begin
                char_stall <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                hold_at    <= hold_at + 130;
            end
            else
                char_stall <= !calm && ($urandom_range(99) < 20);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (char_valid && !char_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHAR_62:  cfg_c62      = value[7:0];
            REG_CHAR_63:  cfg_c63      = value[7:0];
            REG_PAD_SYM:  cfg_pad      = value[7:0];
            REG_PAD_EN:   cfg_pad_en   = value[0];
            REG_LINE_LEN: cfg_line_len = value[9:0];
            default:      ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] d, input logic fin);
        @(negedge clk);
        raw_bytes.push_back('{d, fin});
    endtask

    task automatic queue_message(input int len, input bit close);
        @(negedge clk);
        for (int i = 0; i < len; i++)
            raw_bytes.push_back('{8'($urandom_range(255)), close && (i == len - 1)});
    endtask

    task automatic drain();
        while (raw_bytes.size() != 0 || byte_valid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic random_config();
        logic [9:0] len;
        case ($urandom_range(5))
            0:       len = 10'd0;
            1:       len = 10'd1020;
            2:       len = 10'($urandom_range(1, 8));
            3:       len = 10'($urandom_range(1, 80));
            4:       len = 10'(4 * $urandom_range(1, 19));
            default: len = 10'($urandom_range(1, 1020));
        endcase
        set_reg(REG_CHAR_62, {24'd0, pick_char()});
        set_reg(REG_CHAR_63, {24'd0, pick_char()});
        set_reg(REG_PAD_SYM, {24'd0, pick_char()});
        set_reg(REG_PAD_EN, 32'($urandom_range(1)));
        set_reg(REG_LINE_LEN, {22'd0, len});
    endtask

    initial
    begin
        int sent;
        int len;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // reset settings: one-, two- and three-byte messages, values 62 and 63
        push_byte(8'hFB, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        drain();

        // extreme symbols, no padding, break after every full group
        set_reg(REG_UNUSED, 32'hFFFF_FFFF);
        set_reg(REG_CHAR_62, 32'h00);
        set_reg(REG_CHAR_63, 32'hFF);
        set_reg(REG_PAD_SYM, 32'hFF);
        set_reg(REG_PAD_EN, 32'd0);
        set_reg(REG_LINE_LEN, 32'd4);
        push_byte(8'hFB, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b1);
        drain();

        // line length not a multiple of four, then changed in the middle of a message
        set_reg(REG_PAD_SYM, 32'h00);
        set_reg(REG_PAD_EN, 32'd1);
        set_reg(REG_LINE_LEN, 32'd6);
        queue_message(5, 1'b0);
        drain();
        set_reg(REG_LINE_LEN, 32'd5);
        queue_message(4, 1'b1);
        drain();
        set_reg(REG_LINE_LEN, 32'd1);
        queue_message(2, 1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_config();
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                if ($urandom_range(7) == 0)
                    len = $urandom_range(13, 60);
                else
                    len = $urandom_range(1, 12);
                sent += len;
                queue_message(len, (sent < PHASE_BYTES) || ($urandom_range(3) != 0));
            end
            drain();
        end

        if (err_count == 0 && expected_chars.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
